@@ rtl/stc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// shared types, codes and helpers of the scrollback text console
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned LINE_CNT_W = 32;
  localparam int unsigned COLOR_W    = 24;

  // input kinds
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_UP     = 3'd1;
  localparam logic [2:0] KIND_DOWN   = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // display commands
  localparam logic [2:0] CMD_DRAW    = 3'd0;
  localparam logic [2:0] CMD_ERASE   = 3'd1;
  localparam logic [2:0] CMD_SCROLL  = 3'd2;
  localparam logic [2:0] CMD_REDRAW  = 3'd3;
  localparam logic [2:0] CMD_REPAINT = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_FORE    = 2'd2;
  localparam logic [1:0] REG_BACK    = 2'd3;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam logic [COLOR_W-1:0] FORE_RESET = 24'hFFFFFF;
  localparam logic [8:0]         MAX_ROWS   = 9'd128;

  typedef struct packed {
    logic [8:0]         cols;   // effective, 1..STORE_COLUMNS
    logic [7:0]         rows;   // effective, 1..128
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
  } cfg_t;

  typedef struct packed {
    logic [LINE_CNT_W-1:0] buffer_line;
    logic [COLOR_W-1:0]    back;
    logic [COLOR_W-1:0]    fore;
    logic [7:0]            glyph;
    logic [6:0]            screen_row;
    logic [7:0]            column;
    logic [2:0]            command;
  } result_t;

  function automatic result_t mk_result(logic [2:0] cmd, logic [7:0] col,
                                        logic [6:0] row, logic [7:0] glyph,
                                        logic [COLOR_W-1:0] fg,
                                        logic [COLOR_W-1:0] bg,
                                        logic [LINE_CNT_W-1:0] bline);
    result_t r;
    r.command     = cmd;
    r.column      = col;
    r.screen_row  = row;
    r.glyph       = glyph;
    r.fore        = fg;
    r.back        = bg;
    r.buffer_line = bline;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/stc_cell_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stc_cell_mem
// cell store: character memory and color memory, one write and one
// registered read port each
// ----------------------------------------------------------------------------
module stc_cell_mem #(
  parameter int unsigned ADDR_W = 18
) (
  input  wire logic              clk,
  input  wire logic              we_char,
  input  wire logic              we_color,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wchar,
  input  wire logic [47:0]       wcolor,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [7:0]        rchar,
  output      logic [47:0]       rcolor
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0]  char_mem  [DEPTH];
  logic [47:0] color_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_char) begin
      char_mem[waddr] <= wchar;
    end
    if (re) begin
      rchar <= char_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_color) begin
      color_mem[waddr] <= wcolor;
    end
    if (re) begin
      rcolor <= color_mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/stc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stc_ctrl
// console sequencer: cursor and view state, memory access, row clear and
// store clear sweeps, result list and output beats
// ----------------------------------------------------------------------------
module stc_ctrl #(
  parameter int unsigned RING_LINES    = 1024,
  parameter int unsigned STORE_COLUMNS = 256,
  parameter int unsigned LINE_W        = 10,
  parameter int unsigned COL_W         = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire stc_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [2:0]                in_kind,
  input  wire logic [7:0]                in_char,
  input  wire logic [31:0]               in_line,
  input  wire logic [7:0]                in_col,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      stc_pkg::result_t          out_res,
  output      logic                      out_last,
  output      logic                      we_char,
  output      logic                      we_color,
  output      logic [LINE_W+COL_W-1:0]   waddr,
  output      logic [7:0]                wchar,
  output      logic [47:0]               wcolor,
  output      logic                      re,
  output      logic [LINE_W+COL_W-1:0]   raddr,
  input  wire logic [7:0]                rchar,
  input  wire logic [47:0]               rcolor
);

  localparam int unsigned ADDR_W = LINE_W + COL_W;

  typedef enum logic [4:0] {
    ST_SWEEP  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_ROWCLR = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [31:0]       wl, wl_next;
  logic [8:0]        wc, wc_next;
  logic [31:0]       tv, tv_next;
  logic              sb, sb_next;
  logic [ADDR_W-1:0] cnt;
  logic [LINE_W-1:0] clr_line, clr_line_next;
  logic              rowclr_pend, rowclr_pend_next;
  logic              sweep_pend, sweep_pend_next;
  logic [7:0]        rd_col;
  logic [31:0]       rd_line;
  logic              rd_ok;

  stc_pkg::result_t res [4];
  stc_pkg::result_t res_next [4];
  logic [2:0]        res_cnt, res_cnt_next;
  logic [1:0]        idx;

  // accept-time working values
  logic              accept;
  logic [31:0]       live_top;
  logic [31:0]       tv1;
  logic [31:0]       wl1;
  logic [31:0]       oldest;
  logic [8:0]        wc_dec;
  logic [8:0]        wc_inc;
  logic [8:0]        wc1;
  logic              wrap;
  logic              acc_we_char, acc_we_color;
  logic [ADDR_W-1:0] acc_waddr;
  logic [7:0]        acc_wchar;
  logic [2:0]        n;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign in_ready = (state == ST_IDLE);

  assign live_top = (wl >= {24'd0, cfg.rows}) ? (wl - {24'd0, cfg.rows} + 32'd1) : 32'd0;
  assign oldest   = (wl >= 32'(RING_LINES)) ? (wl - 32'(RING_LINES) + 32'd1) : 32'd0;
  assign wc_dec   = wc - 9'd1;
  assign wc_inc   = wc + 9'd1;

  always_comb begin
    wl_next          = wl;
    wc_next          = wc;
    tv_next          = tv;
    sb_next          = sb;
    clr_line_next    = clr_line;
    rowclr_pend_next = 1'b0;
    sweep_pend_next  = 1'b0;
    acc_we_char      = 1'b0;
    acc_we_color     = 1'b0;
    acc_waddr        = {wl[LINE_W-1:0], wc[COL_W-1:0]};
    acc_wchar        = 8'd0;
    n                = 3'd0;
    tv1              = tv;
    wl1              = wl;
    wc1              = wc;
    wrap             = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res_next[i] = '0;
    end

    unique case (in_kind)
      stc_pkg::KIND_CHAR: begin
        if (sb) begin
          tv1 = live_top;
          sb_next = 1'b0;
          res_next[n[1:0]] = stc_pkg::mk_result(stc_pkg::CMD_REDRAW, 8'd0, 7'd0, 8'd0,
                                                24'd0, cfg.back, live_top);
          n = n + 3'd1;
        end
        if (in_char == stc_pkg::CH_RETURN) begin
          wc1 = 9'd0;
        end else if (in_char == stc_pkg::CH_BACKSPACE) begin
          if (wc != 9'd0) begin
            wc1 = wc_dec;
            acc_waddr = {wl[LINE_W-1:0], wc_dec[COL_W-1:0]};
            acc_we_char = (wc_dec < 9'(STORE_COLUMNS));
            res_next[n[1:0]] = stc_pkg::mk_result(stc_pkg::CMD_ERASE, wc_dec[7:0],
                                                  7'(wl - tv1), 8'd0, 24'd0,
                                                  cfg.back, 32'd0);
            n = n + 3'd1;
          end
        end else begin
          if (in_char == stc_pkg::CH_NEWLINE) begin
            wrap = 1'b1;
          end else begin
            if (wc < cfg.cols) begin
              acc_we_char  = 1'b1;
              acc_we_color = 1'b1;
              acc_wchar    = in_char;
              res_next[n[1:0]] = stc_pkg::mk_result(stc_pkg::CMD_DRAW, wc[7:0],
                                                    7'(wl - tv1), in_char, cfg.fore,
                                                    cfg.back, 32'd0);
              n = n + 3'd1;
              wc1 = wc_inc;
            end
            if (wc1 >= cfg.cols) begin
              wrap = 1'b1;
            end
          end
          if (wrap) begin
            wc1 = 9'd0;
            wl1 = wl + 32'd1;
            rowclr_pend_next = 1'b1;
            clr_line_next = wl1[LINE_W-1:0];
          end
          if ((wl1 - tv1) >= {24'd0, cfg.rows}) begin
            tv1 = wl1 - {24'd0, cfg.rows} + 32'd1;
            res_next[n[1:0]] = stc_pkg::mk_result(stc_pkg::CMD_SCROLL, 8'd0, 7'd0, 8'd0,
                                                  24'd0, cfg.back, 32'd0);
            n = n + 3'd1;
            res_next[n[1:0]] = stc_pkg::mk_result(stc_pkg::CMD_REPAINT, 8'd0,
                                                  7'(cfg.rows - 8'd1), 8'd0, 24'd0,
                                                  24'd0, wl1);
            n = n + 3'd1;
          end
        end
        wl_next = wl1;
        wc_next = wc1;
        tv_next = tv1;
      end
      stc_pkg::KIND_UP: begin
        if (tv != 32'd0 && tv > oldest) begin
          tv_next = tv - 32'd1;
          sb_next = 1'b1;
          res_next[0] = stc_pkg::mk_result(stc_pkg::CMD_REDRAW, 8'd0, 7'd0, 8'd0,
                                           24'd0, cfg.back, tv - 32'd1);
          n = 3'd1;
        end
      end
      stc_pkg::KIND_DOWN: begin
        if (tv < live_top) begin
          tv_next = tv + 32'd1;
          if ((tv + 32'd1) == live_top) begin
            sb_next = 1'b0;
          end
          res_next[0] = stc_pkg::mk_result(stc_pkg::CMD_REDRAW, 8'd0, 7'd0, 8'd0,
                                           24'd0, cfg.back, tv + 32'd1);
          n = 3'd1;
        end
      end
      stc_pkg::KIND_CLEAR: begin
        res_next[0] = stc_pkg::mk_result(stc_pkg::CMD_CLEAR, 8'd0, 7'd0, 8'd0,
                                         24'd0, cfg.back, 32'd0);
        n = 3'd1;
        wl_next = 32'd0;
        wc_next = 9'd0;
        tv_next = 32'd0;
        sb_next = 1'b0;
        sweep_pend_next = 1'b1;
      end
      default: begin
        // read cell is handled in the read state, other kinds do nothing
      end
    endcase
    res_cnt_next = n;
  end

  // memory ports
  always_comb begin
    we_char  = 1'b0;
    we_color = 1'b0;
    waddr    = acc_waddr;
    wchar    = acc_wchar;
    wcolor   = {cfg.back, cfg.fore};
    unique case (state)
      ST_SWEEP: begin
        we_char  = 1'b1;
        we_color = 1'b1;
        waddr    = cnt;
        wchar    = 8'd0;
        wcolor   = 48'd0;
      end
      ST_ROWCLR: begin
        we_char = 1'b1;
        waddr   = {clr_line, cnt[COL_W-1:0]};
        wchar   = 8'd0;
      end
      ST_IDLE: begin
        we_char  = accept && (in_kind == stc_pkg::KIND_CHAR) && acc_we_char;
        we_color = accept && (in_kind == stc_pkg::KIND_CHAR) && acc_we_color;
      end
      default: begin
      end
    endcase
  end

  assign re    = accept && (in_kind == stc_pkg::KIND_READ);
  assign raddr = {in_line[LINE_W-1:0], in_col[COL_W-1:0]};

  assign out_valid = (state == ST_EMIT);
  assign out_res   = res[idx];
  assign out_last  = ({1'b0, idx} == (res_cnt - 3'd1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_ROWCLR: begin
        if (cnt[COL_W-1:0] == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == stc_pkg::KIND_READ) begin
            state_next = ST_READ;
          end else if (res_cnt_next != 3'd0) begin
            state_next = ST_EMIT;
          end else if (rowclr_pend_next) begin
            state_next = ST_ROWCLR;
          end
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && out_last) begin
          if (sweep_pend) begin
            state_next = ST_SWEEP;
          end else if (rowclr_pend) begin
            state_next = ST_ROWCLR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      cnt         <= '0;
      wl          <= 32'd0;
      wc          <= 9'd0;
      tv          <= 32'd0;
      sb          <= 1'b0;
      rowclr_pend <= 1'b0;
      sweep_pend  <= 1'b0;
      res_cnt     <= 3'd0;
      idx         <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP || state == ST_ROWCLR) begin
        cnt <= (state_next == ST_IDLE) ? '0 : cnt + 1'b1;
      end
      if (accept) begin
        wl          <= wl_next;
        wc          <= wc_next;
        tv          <= tv_next;
        sb          <= sb_next;
        rowclr_pend <= rowclr_pend_next;
        sweep_pend  <= sweep_pend_next;
        res_cnt     <= res_cnt_next;
        idx         <= 2'd0;
      end else if (state == ST_READ) begin
        res_cnt <= 3'd1;
        idx     <= 2'd0;
      end else if (state == ST_EMIT && out_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res      <= res_next;
      clr_line <= clr_line_next;
      rd_col   <= in_col;
      rd_line  <= in_line;
      rd_ok    <= ({1'b0, in_col} < 9'(STORE_COLUMNS));
    end else if (state == ST_READ) begin
      res[0] <= stc_pkg::mk_result(stc_pkg::CMD_READ, rd_col, 7'd0,
                                   rd_ok ? rchar : 8'd0,
                                   rd_ok ? rcolor[23:0] : 24'd0,
                                   rd_ok ? rcolor[47:24] : 24'd0, rd_line);
    end
  end

endmodule
`default_nettype wire

@@ rtl/scrollback_text_console_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scrollback_text_console_top
// text console engine with a ring scrollback cell store and display commands
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A character, scroll or clear beat is
// decoded in its accept cycle and its up to four command beats follow from
// the next cycle, one per cycle while the sink is ready; a cell read first
// passes the read state for the registered memory read. After a newline or a
// wrap the new write row has its characters cleared through the memory write
// port, one cell per cycle, STORE_COLUMNS cells (256 by default), before the
// next beat is taken. After reset and after a clear beat the whole store is
// zeroed the same way, RING_LINES * STORE_COLUMNS cells (262144 by default),
// while no input beat is taken; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module scrollback_text_console_top #(
  parameter int unsigned RING_LINES    = 1024,  // power of two, 64..65536
  parameter int unsigned STORE_COLUMNS = 256    // power of two, 16..256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input stream
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire logic [47:0]  s_tdata,   // char_code[7:0], read_line[39:8], read_column[47:40]
  input  wire logic [2:0]   s_tuser,   // kind[2:0]
  // command stream
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [103:0] m_tdata,   // column[7:0], screen_row[14:8], glyph[22:15],
                                       // glyph_fore[46:23], glyph_back[70:47],
                                       // buffer_line[102:71], zero[103]
  output      logic [2:0]   m_tuser,   // command[2:0]
  output      logic         m_tlast,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);

  localparam int unsigned LINE_W = $clog2(RING_LINES);
  localparam int unsigned COL_W  = $clog2(STORE_COLUMNS);
  localparam int unsigned ADDR_W = LINE_W + COL_W;

  // configuration registers
  logic [8:0]  columns_in_use;
  logic [7:0]  rows_on_screen;
  logic [23:0] fore_color;
  logic [23:0] back_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 9'd128;
      rows_on_screen <= 8'd48;
      fore_color     <= stc_pkg::FORE_RESET;
      back_color     <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stc_pkg::REG_COLUMNS: columns_in_use <= cfg_data[8:0];
        stc_pkg::REG_ROWS:    rows_on_screen <= cfg_data[7:0];
        stc_pkg::REG_FORE:    fore_color     <= cfg_data;
        stc_pkg::REG_BACK:    back_color     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize saturates
  stc_pkg::cfg_t cfg;

  always_comb begin
    if (columns_in_use == 9'd0) begin
      cfg.cols = 9'd1;
    end else if (columns_in_use > 9'(STORE_COLUMNS)) begin
      cfg.cols = 9'(STORE_COLUMNS);
    end else begin
      cfg.cols = columns_in_use;
    end
    if (rows_on_screen == 8'd0) begin
      cfg.rows = 8'd1;
    end else if ({1'b0, rows_on_screen} > stc_pkg::MAX_ROWS) begin
      cfg.rows = stc_pkg::MAX_ROWS[7:0];
    end else begin
      cfg.rows = rows_on_screen;
    end
    cfg.fore = fore_color;
    cfg.back = back_color;
  end

  // sequencer to memory
  logic              we_char, we_color, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wchar, rchar;
  logic [47:0]       wcolor, rcolor;

  stc_pkg::result_t  res;

  stc_ctrl #(
    .RING_LINES    (RING_LINES),
    .STORE_COLUMNS (STORE_COLUMNS),
    .LINE_W        (LINE_W),
    .COL_W         (COL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_line   (s_tdata[39:8]),
    .in_col    (s_tdata[47:40]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .out_last  (m_tlast),
    .we_char   (we_char),
    .we_color  (we_color),
    .waddr     (waddr),
    .wchar     (wchar),
    .wcolor    (wcolor),
    .re        (re),
    .raddr     (raddr),
    .rchar     (rchar),
    .rcolor    (rcolor)
  );

  stc_cell_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .we_char  (we_char),
    .we_color (we_color),
    .waddr    (waddr),
    .wchar    (wchar),
    .wcolor   (wcolor),
    .re       (re),
    .raddr    (raddr),
    .rchar    (rchar),
    .rcolor   (rcolor)
  );

  // pack the command beat
  assign m_tuser = res.command;
  assign m_tdata = {1'b0, res.buffer_line, res.back, res.fore, res.glyph,
                    res.screen_row, res.column};

endmodule
`default_nettype wire

@@ dv/tb_scrollback_text_console_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scrollback_text_console_top
// self-checking bench for the scrollback text console engine
// ----------------------------------------------------------------------------
// Input beats are sent in random bursts and mirrored into a behavioral
// console model at acceptance. The model keeps its own cell store, cursor and
// view state, and queues the display command beats it predicts. A monitor
// compares each command beat with the oldest queued one, field by field.
// The sink stalls on a pattern of its own. Configuration is only written
// while the engine is idle.
// ----------------------------------------------------------------------------
module tb_scrollback_text_console_top;

  localparam int unsigned RING  = 1024;
  localparam int unsigned SCOLS = 256;
  localparam int unsigned CELLS = RING * SCOLS;
  // two full store clears plus every item at its slowest, taken several times over
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE = 400;   // > one row clear after the last beat

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [31:0] bline;
    logic        last;
  } cmd_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  scrollback_text_console_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------- console model ----------------
  logic [7:0]  cell_chr [CELLS];
  logic [23:0] cell_fg  [CELLS];
  logic [23:0] cell_bg  [CELLS];
  logic [8:0]  cols_reg;
  logic [7:0]  rows_reg;
  logic [23:0] fore_reg;
  logic [23:0] back_reg;
  logic [31:0] wline;
  logic [31:0] wcol;
  logic [31:0] top_line;
  logic        backscroll;

  cmd_beat_t pending_cmds[$];
  int        errors = 0;
  longint unsigned cycles = 0;
  int        burst_left = 0;

  function automatic int unsigned cidx(logic [31:0] line, logic [31:0] col);
    return (line % RING) * SCOLS + col;
  endfunction

  function automatic logic [31:0] live_top(logic [31:0] rows);
    return (wline >= rows) ? wline - rows + 1 : 32'd0;
  endfunction

  task automatic wipe_store();
    for (int i = 0; i < CELLS; i++) begin
      cell_chr[i] = '0; cell_fg[i] = '0; cell_bg[i] = '0;
    end
  endtask

  task automatic clear_row(logic [31:0] line);
    for (int c = 0; c < SCOLS; c++) cell_chr[cidx(line, c)] = '0;
  endtask

  function automatic cmd_beat_t mk(logic [2:0] cmd, logic [31:0] col, logic [31:0] row,
                                   logic [7:0] g, logic [23:0] fg, logic [23:0] bg,
                                   logic [31:0] bl);
    cmd_beat_t b;
    b.cmd = cmd; b.col = col[7:0]; b.row = row[6:0]; b.glyph = g;
    b.fg = fg; b.bg = bg; b.bline = bl; b.last = 1'b0;
    return b;
  endfunction

  // expected display commands of one accepted input beat
  task automatic console_predict(logic [2:0] kind, logic [7:0] ch, logic [31:0] rline,
                                 logic [7:0] rcol);
    cmd_beat_t  outq[$];
    logic [31:0] cols, rows, oldest, lt;
    int unsigned i;
    cols = (cols_reg == 0) ? 1 : (cols_reg > SCOLS) ? SCOLS : cols_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > 128) ? 128 : rows_reg;
    case (kind)
      stc_pkg::KIND_CHAR: begin
        // typing while scrolled back snaps to the live view first
        if (backscroll) begin
          backscroll = 1'b0;
          top_line = live_top(rows);
          outq.push_back(mk(stc_pkg::CMD_REDRAW, 0, 0, 0, 0, back_reg, top_line));
        end
        if (ch == stc_pkg::CH_RETURN) begin
          wcol = 0;
        end else if (ch == stc_pkg::CH_BACKSPACE) begin
          if (wcol > 0) begin
            wcol--;
            if (wcol < SCOLS) cell_chr[cidx(wline, wcol)] = '0;
            outq.push_back(mk(stc_pkg::CMD_ERASE, wcol, wline - top_line, 0, 0,
                              back_reg, 0));
          end
        end else begin
          if (ch == stc_pkg::CH_NEWLINE) begin
            wcol = 0; wline++; clear_row(wline);
          end else begin
            // column past a lowered limit writes nothing, only wraps
            if (wcol < cols) begin
              i = cidx(wline, wcol);
              cell_chr[i] = ch; cell_fg[i] = fore_reg; cell_bg[i] = back_reg;
              outq.push_back(mk(stc_pkg::CMD_DRAW, wcol, wline - top_line, ch, fore_reg,
                                back_reg, 0));
              wcol++;
            end
            if (wcol >= cols) begin
              wcol = 0; wline++; clear_row(wline);
            end
          end
          if (wline - top_line >= rows) begin
            top_line = wline - rows + 1;
            outq.push_back(mk(stc_pkg::CMD_SCROLL, 0, 0, 0, 0, back_reg, 0));
            outq.push_back(mk(stc_pkg::CMD_REPAINT, 0, rows - 1, 0, 0, 0, wline));
          end
        end
      end
      stc_pkg::KIND_UP: begin
        oldest = (wline >= RING) ? wline - RING + 1 : 0;
        if (top_line > 0 && top_line > oldest) begin
          top_line--; backscroll = 1'b1;
          outq.push_back(mk(stc_pkg::CMD_REDRAW, 0, 0, 0, 0, back_reg, top_line));
        end
      end
      stc_pkg::KIND_DOWN: begin
        lt = live_top(rows);
        if (top_line < lt) begin
          top_line++;
          if (top_line == lt) backscroll = 1'b0;
          outq.push_back(mk(stc_pkg::CMD_REDRAW, 0, 0, 0, 0, back_reg, top_line));
        end
      end
      stc_pkg::KIND_CLEAR: begin
        outq.push_back(mk(stc_pkg::CMD_CLEAR, 0, 0, 0, 0, back_reg, 0));
        wline = 0; wcol = 0; top_line = 0; backscroll = 1'b0;
        wipe_store();
      end
      stc_pkg::KIND_READ: begin
        i = cidx(rline, rcol);
        outq.push_back(mk(stc_pkg::CMD_READ, rcol, 0, cell_chr[i], cell_fg[i], cell_bg[i],
                          rline));
      end
      default: ;  // unused kinds are dropped
    endcase
    if (outq.size() > 0) outq[outq.size() - 1].last = 1'b1;
    foreach (outq[k]) pending_cmds.push_back(outq[k]);
  endtask

  // ---------------- stimulus helpers ----------------
  // one input beat; the sender runs in bursts with random gaps in between
  task automatic send_beat(logic [2:0] kind, logic [7:0] ch, logic [31:0] rline,
                           logic [7:0] rcol);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {rcol, rline, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    console_predict(kind, ch, rline, rcol);
    burst_left--;
  endtask

  task automatic type_char(logic [7:0] ch);
    send_beat(stc_pkg::KIND_CHAR, ch, 32'($urandom), 8'($urandom));
  endtask

  // drain every expected beat, then let a trailing row clear finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      stc_pkg::REG_COLUMNS: cols_reg = val[8:0];
      stc_pkg::REG_ROWS:    rows_reg = val[7:0];
      stc_pkg::REG_FORE:    fore_reg = val;
      default:              back_reg = val;
    endcase
  endtask

  // ---------------- sink and checker ----------------
  int stall_mode = 0;
  int stall_cnt  = 0;

  task automatic chk(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cmd_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t unexpected beat cmd %h actual %h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        chk("command", 32'(e.cmd), 32'(m_tuser));
        chk("column", 32'(e.col), 32'(m_tdata[7:0]));
        chk("screen_row", 32'(e.row), 32'(m_tdata[14:8]));
        chk("glyph", 32'(e.glyph), 32'(m_tdata[22:15]));
        chk("glyph_fore", 32'(e.fg), 32'(m_tdata[46:23]));
        chk("glyph_back", 32'(e.bg), 32'(m_tdata[70:47]));
        chk("buffer_line", e.bline, m_tdata[102:71]);
        chk("pad", 32'd0, 32'(m_tdata[103]));
        chk("last", 32'(e.last), 32'(m_tlast));
      end
    end
    // sink pattern: always ready, coin flip, or long stalls, rotated
    stall_cnt++;
    if (stall_cnt >= 97) begin
      stall_cnt = 0;
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    // extremes of the byte at reset settings, then read them back
    type_char(8'hFF);
    type_char(8'h00);
    type_char(8'h41);
    send_beat(stc_pkg::KIND_READ, 8'd0, 32'd0, 8'd0);
    send_beat(stc_pkg::KIND_READ, 8'd0, 32'hFFFF_FC00, 8'd2);
    send_beat(stc_pkg::KIND_READ, 8'd0, 32'd0, 8'd255);
  endtask

  task automatic test_control_chars();
    type_char(stc_pkg::CH_RETURN);         // return: column to zero, no beats
    type_char(stc_pkg::CH_BACKSPACE);      // backspace at column zero: nothing
    type_char(8'h5A);
    type_char(stc_pkg::CH_BACKSPACE);
    type_char(stc_pkg::CH_NEWLINE);
    send_beat(stc_pkg::KIND_READ, 8'd0, 32'd1, 8'd0);
  endtask

  task automatic test_wrap_and_limit();
    wait_idle();
    write_reg(stc_pkg::REG_FORE, 24'h000000);
    write_reg(stc_pkg::REG_BACK, 24'hFFFFFF);
    for (int k = 0; k < 6; k++) type_char(8'(8'h30 + k));
    wait_idle();
    // limit lowered under the cursor: nothing written, line wraps
    write_reg(stc_pkg::REG_COLUMNS, 24'd3);
    type_char(8'h61);
    type_char(8'h62);
  endtask

  task automatic test_scrollback();
    wait_idle();
    write_reg(stc_pkg::REG_ROWS, 24'd2);
    write_reg(stc_pkg::REG_COLUMNS, 24'd0);   // acts as one column
    for (int k = 0; k < 4; k++) type_char(8'(8'h70 + k));
    send_beat(stc_pkg::KIND_UP, 8'd0, 32'd0, 8'd0);
    send_beat(stc_pkg::KIND_UP, 8'd0, 32'd0, 8'd0);
    send_beat(stc_pkg::KIND_DOWN, 8'd0, 32'd0, 8'd0);
    type_char(8'h7E);                                 // typing while scrolled back
    send_beat(stc_pkg::KIND_DOWN, 8'd0, 32'd0, 8'd0); // at the live view: ignored
  endtask

  task automatic test_clear_and_unused();
    send_beat(3'd5, 8'd0, 32'd0, 8'd0);
    send_beat(3'd7, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_beat(stc_pkg::KIND_CLEAR, 8'd0, 32'd0, 8'd0);
    send_beat(stc_pkg::KIND_UP, 8'd0, 32'd0, 8'd0);    // at the oldest line: ignored
    send_beat(stc_pkg::KIND_READ, 8'd0, 32'd2, 8'd0);
  endtask

  task automatic random_config();
    int r;
    wait_idle();
    r = $urandom_range(0, 9);
    write_reg(stc_pkg::REG_COLUMNS, r == 0 ? 24'd256 : r == 1 ? 24'h1FF :
              r == 2 ? 24'(9'h100 | $urandom_range(0, 255)) : 24'($urandom_range(1, 24)));
    r = $urandom_range(0, 9);
    write_reg(stc_pkg::REG_ROWS, r == 0 ? 24'd128 : r == 1 ? 24'hFF : r == 2 ? 24'd0 :
              24'($urandom_range(1, 6)));
    write_reg(stc_pkg::REG_FORE, 24'($urandom));
    write_reg(stc_pkg::REG_BACK, 24'($urandom));
  endtask

  task automatic test_random_traffic();
    int r;
    int sent = 0;
    while (sent < 370) begin
      if (sent % 70 == 0) random_config();
      if (sent == 185) begin
        // hold the sender until every command has come out
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_cmds.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 15)      type_char(stc_pkg::CH_NEWLINE);
        else if (r < 20) type_char(stc_pkg::CH_RETURN);
        else if (r < 28) type_char(stc_pkg::CH_BACKSPACE);
        else if (r < 33) type_char(8'($urandom));
        else             type_char(8'($urandom_range(32, 126)));
      end else if (r < 70) begin
        send_beat(stc_pkg::KIND_UP, 8'($urandom), 32'($urandom), 8'($urandom));
      end else if (r < 78) begin
        send_beat(stc_pkg::KIND_DOWN, 8'($urandom), 32'($urandom), 8'($urandom));
      end else if (r < 96) begin
        send_beat(stc_pkg::KIND_READ, 8'($urandom),
                  $urandom_range(0, 4) == 0 ? 32'($urandom)
                                            : 32'(wline - $urandom_range(0, 8)),
                  $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 24)));
      end else begin
        send_beat(3'($urandom_range(5, 7)), 8'($urandom), 32'($urandom), 8'($urandom));
        sent--;   // ignored beats are not counted
      end
      sent++;
    end
  endtask

  initial begin
    cols_reg = 9'd128; rows_reg = 8'd48; fore_reg = stc_pkg::FORE_RESET; back_reg = '0;
    wline = 0; wcol = 0; top_line = 0; backscroll = 1'b0;
    wipe_store();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_control_chars();
    test_wrap_and_limit();
    test_scrollback();
    test_clear_and_unused();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
